FILE: sv/icfe_pkg.sv
// Shared types, constants and helper functions for the Ising cluster flip engine.
// Used by icfe_ctrl, icfe_dp and ising_cluster_flip_engine_core.
package icfe_pkg;

  localparam int SIDE        = 32;
  localparam int SIDE_W      = $clog2(SIDE);
  localparam int CELLS       = SIDE * SIDE;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int STACK_DEPTH = 4 * CELLS;
  localparam int STACK_W     = $clog2(STACK_DEPTH);
  localparam int SP_W        = STACK_W + 1;
  localparam int TRIED_W     = 13;
  localparam int ENERGY_W    = 13;
  localparam int MAG_W       = 11;
  localparam int THR_W       = 16;
  localparam int PRNG_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int DIS_W       = $clog2(2 * CELLS + 1);
  localparam int ONES_W      = $clog2(CELLS + 1);
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;

  typedef logic [ADDR_W-1:0] site_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SEED      = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SEED_RD,
    ST_SEED_FLIP,
    ST_NB_RD,
    ST_NB_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_CUR_CHK,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic init_step;
    logic accept;
    logic seed_rd;
    logic seed_flip;
    logic nb_rd;
    logic nb_chk;
    logic pop;
    logic pop_wait;
    logic cur_chk;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic k_last;
    logic sp_zero;
    logic cur_join;
    logic out_free;
  } status_t;

  function automatic logic [PRNG_W-1:0] xorshift(input logic [PRNG_W-1:0] x);
    logic [PRNG_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  function automatic site_t neighbor(input site_t s, input dir_t dir);
    logic [SIDE_W-1:0] r;
    logic [SIDE_W-1:0] c;
    r = SIDE_W'(s / SIDE);
    c = SIDE_W'(s % SIDE);
    unique case (dir)
      DIR_UP:    r = (r == '0) ? SIDE_W'(SIDE - 1) : r - 1'b1;
      DIR_DOWN:  r = (r == SIDE_W'(SIDE - 1)) ? '0 : r + 1'b1;
      DIR_LEFT:  c = (c == '0) ? SIDE_W'(SIDE - 1) : c - 1'b1;
      DIR_RIGHT: c = (c == SIDE_W'(SIDE - 1)) ? '0 : c + 1'b1;
      default:   r = r;
    endcase
    return ADDR_W'(r * SIDE + c);
  endfunction

endpackage

FILE: sv/icfe_ctrl.sv
// Sequencing state machine of the cluster flip engine.
// Depends on icfe_pkg; drives icfe_dp through cmd_t and reads status_t.
module icfe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  icfe_pkg::status_t sts,
  output icfe_pkg::cmd_t    cmd
);

  icfe_pkg::state_t state;
  icfe_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= icfe_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      icfe_pkg::ST_INIT:      if (sts.cnt_last) state_next = icfe_pkg::ST_IDLE;
      icfe_pkg::ST_IDLE:      if (in_tvalid) state_next = icfe_pkg::ST_SEED_RD;
      icfe_pkg::ST_SEED_RD:   state_next = icfe_pkg::ST_SEED_FLIP;
      icfe_pkg::ST_SEED_FLIP: state_next = icfe_pkg::ST_NB_RD;
      icfe_pkg::ST_NB_RD:     state_next = icfe_pkg::ST_NB_CHK;
      icfe_pkg::ST_NB_CHK: begin
        state_next = sts.k_last ? icfe_pkg::ST_POP : icfe_pkg::ST_NB_RD;
      end
      icfe_pkg::ST_POP: begin
        state_next = sts.sp_zero ? icfe_pkg::ST_SCAN : icfe_pkg::ST_POP_WAIT;
      end
      icfe_pkg::ST_POP_WAIT:  state_next = icfe_pkg::ST_CUR_CHK;
      icfe_pkg::ST_CUR_CHK: begin
        state_next = sts.cur_join ? icfe_pkg::ST_NB_RD : icfe_pkg::ST_POP;
      end
      icfe_pkg::ST_SCAN:      if (sts.cnt_last) state_next = icfe_pkg::ST_SCAN_END;
      icfe_pkg::ST_SCAN_END:  state_next = icfe_pkg::ST_DONE;
      icfe_pkg::ST_DONE:      if (sts.out_free) state_next = icfe_pkg::ST_IDLE;
      default:                state_next = icfe_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state)
      icfe_pkg::ST_INIT:      cmd.init_step = 1'b1;
      icfe_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      icfe_pkg::ST_SEED_RD:   cmd.seed_rd   = 1'b1;
      icfe_pkg::ST_SEED_FLIP: cmd.seed_flip = 1'b1;
      icfe_pkg::ST_NB_RD:     cmd.nb_rd     = 1'b1;
      icfe_pkg::ST_NB_CHK:    cmd.nb_chk    = 1'b1;
      icfe_pkg::ST_POP:       cmd.pop       = !sts.sp_zero;
      icfe_pkg::ST_POP_WAIT:  cmd.pop_wait  = 1'b1;
      icfe_pkg::ST_CUR_CHK:   cmd.cur_chk   = 1'b1;
      icfe_pkg::ST_SCAN:      cmd.scan_step = 1'b1;
      icfe_pkg::ST_SCAN_END:  cmd           = '0;
      icfe_pkg::ST_DONE:      cmd.load_out  = sts.out_free;
      default:                cmd           = '0;
    endcase
  end

endmodule

FILE: sv/icfe_dp.sv
// Datapath of the cluster flip engine: lattice and mark memories, pending stack,
// xorshift generator, energy/magnetization scan and result register. Uses icfe_pkg.
module icfe_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  icfe_pkg::cmd_t                      cmd,
  output icfe_pkg::status_t                   sts,
  input  logic [icfe_pkg::SIDE_W-1:0]         start_row,
  input  logic [icfe_pkg::SIDE_W-1:0]         start_col,
  input  logic                                cfg_we,
  input  logic [icfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icfe_pkg::PRNG_W-1:0]         cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [icfe_pkg::TRIED_W-1:0]        tried_count,
  output logic signed [icfe_pkg::ENERGY_W-1:0] energy,
  output logic [icfe_pkg::MAG_W-1:0]          magnetization
);

  logic spin_mem [icfe_pkg::CELLS];
  logic mark_mem [icfe_pkg::CELLS];
  icfe_pkg::site_t stk_mem [icfe_pkg::STACK_DEPTH];

  logic [icfe_pkg::THR_W-1:0]  thr;
  logic [icfe_pkg::PRNG_W-1:0] prng;
  logic [icfe_pkg::PRNG_W-1:0] prng_adv;
  logic [icfe_pkg::THR_W-1:0]  draw;

  icfe_pkg::site_t cnt;
  icfe_pkg::site_t base;
  icfe_pkg::site_t nb_q;
  icfe_pkg::site_t nb_addr;
  icfe_pkg::site_t rd_addr;
  icfe_pkg::site_t down_addr;
  logic [1:0]      k;
  logic            grow;
  logic            orig;
  logic [icfe_pkg::SP_W-1:0]    sp;
  logic [icfe_pkg::SP_W-1:0]    sp_dec;
  logic [icfe_pkg::TRIED_W-1:0] tried;

  logic            spin_rd_a;
  logic            spin_rd_b;
  logic            mark_rd;
  icfe_pkg::site_t stk_rd;

  logic            spin_we;
  logic            spin_wd;
  icfe_pkg::site_t spin_wa;
  logic            mark_we;
  logic            mark_wd;
  icfe_pkg::site_t mark_wa;
  logic            push;
  logic            cur_match;

  logic            scan_vld;
  icfe_pkg::site_t scan_addr;
  logic [icfe_pkg::SIDE_W-1:0] scan_col;
  logic            prev_s;
  logic            first_s;
  logic [1:0]      dis_inc;
  logic [icfe_pkg::DIS_W-1:0]  dis;
  logic [icfe_pkg::ONES_W-1:0] ones;
  logic [icfe_pkg::ENERGY_W:0] energy_wide;
  logic signed [icfe_pkg::ENERGY_W-1:0] mag_signed;
  logic [icfe_pkg::ENERGY_W-1:0] mag_abs;

  assign prng_adv  = icfe_pkg::xorshift(prng);
  assign draw      = prng_adv[icfe_pkg::PRNG_W-1 -: icfe_pkg::THR_W];
  assign cur_match = (spin_rd_a == orig);
  assign sp_dec    = sp - 1'b1;
  assign nb_addr   = icfe_pkg::neighbor(base, icfe_pkg::dir_t'(grow ? (k ^ 2'd1) : k));
  assign down_addr = icfe_pkg::neighbor(cnt, icfe_pkg::DIR_DOWN);

  always_comb begin
    priority if (cmd.nb_rd)     rd_addr = nb_addr;
    else if (cmd.pop_wait)      rd_addr = stk_rd;
    else if (cmd.scan_step)     rd_addr = cnt;
    else if (cmd.seed_rd)       rd_addr = base;
    else                        rd_addr = base;
  end

  always_comb begin
    spin_we = 1'b0;
    spin_wa = cnt;
    spin_wd = 1'b1;
    mark_we = 1'b0;
    mark_wa = cnt;
    mark_wd = 1'b0;
    priority if (cmd.init_step) begin
      spin_we = 1'b1;
      mark_we = 1'b1;
    end else if (cmd.scan_step) begin
      mark_we = 1'b1;
    end else if (cmd.seed_flip) begin
      spin_we = 1'b1;
      spin_wa = base;
      spin_wd = !spin_rd_a;
      mark_we = 1'b1;
      mark_wa = base;
      mark_wd = 1'b1;
    end else if (cmd.cur_chk && cur_match && (draw < thr)) begin
      spin_we = 1'b1;
      spin_wa = base;
      spin_wd = !orig;
      mark_we = 1'b1;
      mark_wa = base;
      mark_wd = 1'b1;
    end
  end

  // push when the neighbor still qualifies: same spin at the seed, unmarked in growth
  assign push = cmd.nb_chk && (grow ? !mark_rd : (spin_rd_a == orig))
                && (sp < icfe_pkg::SP_W'(icfe_pkg::STACK_DEPTH));

  always_ff @(posedge clk) begin
    if (spin_we) spin_mem[spin_wa] <= spin_wd;
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (push) stk_mem[sp[icfe_pkg::STACK_W-1:0]] <= nb_q;
    spin_rd_a <= spin_mem[rd_addr];
    spin_rd_b <= spin_mem[down_addr];
    mark_rd   <= mark_mem[rd_addr];
    stk_rd    <= stk_mem[sp_dec[icfe_pkg::STACK_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= '0;
      prng <= icfe_pkg::PRNG_W'(1);
    end else begin
      if (cfg_we && cfg_index == icfe_pkg::REG_THRESHOLD) begin
        thr <= cfg_data[icfe_pkg::THR_W-1:0];
      end
      if (cfg_we && cfg_index == icfe_pkg::REG_SEED) begin
        prng <= (cfg_data == '0) ? icfe_pkg::PRNG_W'(1) : cfg_data;
      end else if (cmd.cur_chk && cur_match) begin
        prng <= prng_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      sp    <= '0;
      k     <= '0;
      grow  <= 1'b0;
    end else begin
      if (cmd.init_step || cmd.scan_step) cnt <= cnt + 1'b1;
      if (cmd.accept) grow <= 1'b0;
      if (cmd.seed_flip) k <= '0;
      if (cmd.cur_chk && cur_match && (draw < thr)) begin
        grow <= 1'b1;
        k    <= '0;
      end
      if (cmd.nb_chk) k <= k + 1'b1;
      if (push) begin
        sp <= sp + 1'b1;
      end else if (cmd.pop) begin
        sp <= sp_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base  <= icfe_pkg::ADDR_W'(start_row * icfe_pkg::SIDE + start_col);
      tried <= icfe_pkg::TRIED_W'(1);
    end
    if (cmd.seed_flip) orig <= spin_rd_a;
    if (cmd.nb_rd) nb_q <= nb_addr;
    if (cmd.pop) tried <= tried + 1'b1;
    if (cmd.pop_wait) base <= stk_rd;
  end

  // scan: row-major; down bond, left bond from the previous site, wrap bond from row head
  assign scan_col = icfe_pkg::SIDE_W'(scan_addr % icfe_pkg::SIDE);
  always_comb begin
    dis_inc = {1'b0, spin_rd_a != spin_rd_b};
    if (scan_col != '0 && spin_rd_a != prev_s) dis_inc = dis_inc + 1'b1;
    if (scan_col == icfe_pkg::SIDE_W'(icfe_pkg::SIDE - 1) && spin_rd_a != first_s) begin
      dis_inc = dis_inc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld <= 1'b0;
    end else begin
      scan_vld <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr <= cnt;
    if (cmd.accept) begin
      dis  <= '0;
      ones <= '0;
    end else if (scan_vld) begin
      dis    <= dis + icfe_pkg::DIS_W'(dis_inc);
      ones   <= ones + icfe_pkg::ONES_W'(spin_rd_a);
      prev_s <= spin_rd_a;
      if (scan_col == '0) first_s <= spin_rd_a;
    end
  end

  assign energy_wide = {1'b0, dis, 1'b0} - (icfe_pkg::ENERGY_W + 1)'(2 * icfe_pkg::CELLS);
  assign mag_signed  = $signed({1'b0, ones, 1'b0}) - icfe_pkg::ENERGY_W'(icfe_pkg::CELLS);
  assign mag_abs     = mag_signed[icfe_pkg::ENERGY_W-1] ? -mag_signed : mag_signed;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      tried_count   <= tried;
      energy        <= $signed(energy_wide[icfe_pkg::ENERGY_W-1:0]);
      magnetization <= mag_abs[icfe_pkg::MAG_W-1:0];
    end
  end

  assign sts.cnt_last = (cnt == icfe_pkg::ADDR_W'(icfe_pkg::CELLS - 1));
  assign sts.k_last   = (k == 2'd3);
  assign sts.sp_zero  = (sp == '0);
  assign sts.cur_join = cur_match && (draw < thr);
  assign sts.out_free = !out_tvalid || out_tready;

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= icfe_pkg::SP_W'(icfe_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> sp != '0)
    else $error("pop from empty stack");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_tvalid)
    else $error("result not presented after load");
  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(push && cmd.pop))
    else $error("push and pop in one cycle");

endmodule

FILE: sv/ising_cluster_flip_engine_core.sv
// Top level of the Wolff cluster flip engine for a periodic 2-D Ising lattice.
// Instantiates icfe_ctrl and icfe_dp; uses icfe_pkg.
//
// Use: each transaction on the s_axis channel names a seed site; the engine grows
// one Wolff cluster from it, flips it, and returns one m_axis transaction holding
// the trial count, the lattice energy and the absolute magnetization.
// Configuration writes go over the cfg channel (index 0: acceptance threshold in
// Q0.16, index 1: generator seed, zero loads 1); cfg_ready is always high, and
// writes are expected only while the engine is idle. Unknown indexes are ignored.
// One item is worked on at a time: the cluster grows from the seed, then a row-major
// energy scan runs, which also clears the cluster marks.
// Reset: synchronous; afterwards a sweep over all cells loads all spins to +1 and
// clears all marks; s_axis_tready stays low until it ends.
// A stalled receiver holds the result in the output register; the engine still takes and
// works a new item, but holds back its result until the register empties.
module ising_cluster_flip_engine_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [icfe_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // start_row[4:0], start_col[9:5]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [icfe_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // tried_count[12:0], energy[25:13], magnetization[36:26]
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [icfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [icfe_pkg::PRNG_W-1:0]          cfg_data
);

  icfe_pkg::cmd_t    cmd;
  icfe_pkg::status_t sts;
  logic [icfe_pkg::TRIED_W-1:0]         tried_count;
  logic signed [icfe_pkg::ENERGY_W-1:0] energy;
  logic [icfe_pkg::MAG_W-1:0]           magnetization;

  assign cfg_ready = 1'b1;

  icfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  icfe_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .start_row     (s_axis_tdata[icfe_pkg::SIDE_W-1:0]),
    .start_col     (s_axis_tdata[2*icfe_pkg::SIDE_W-1:icfe_pkg::SIDE_W]),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_tvalid    (m_axis_tvalid),
    .out_tready    (m_axis_tready),
    .tried_count   (tried_count),
    .energy        (energy),
    .magnetization (magnetization)
  );

  assign m_axis_tdata = {3'b000, magnetization, energy, tried_count};

endmodule

FILE: tb/tb.sv
// Self-checking bench for ising_cluster_flip_engine_core: seeds Wolff cluster updates,
// predicts trial count, energy and magnetization in place, and checks every result.
// Depends on icfe_pkg and the engine RTL.
module tb;

  localparam logic [icfe_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 15000000;

  // highest field first, matching m_axis_tdata
  typedef struct packed {
    logic [icfe_pkg::MAG_W-1:0]    mag;
    logic [icfe_pkg::ENERGY_W-1:0] energy;
    logic [icfe_pkg::TRIED_W-1:0]  tried;
  } flip_result_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [icfe_pkg::IN_DATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [icfe_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [icfe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [icfe_pkg::PRNG_W-1:0] cfg_data;

  // lattice model
  bit [icfe_pkg::CELLS-1:0] lat_spin;
  bit [icfe_pkg::CELLS-1:0] lat_mark;
  logic [icfe_pkg::THR_W-1:0] thr_q;
  logic [icfe_pkg::PRNG_W-1:0] prng_q;

  logic [icfe_pkg::IN_DATA_W-1:0] seed_sites[$];
  flip_result_t expected_flips[$];
  int mismatches;
  bit quiet;
  int src_gap;
  int snk_gap;
  int cycles;

  ising_cluster_flip_engine_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int site_of(int r, int c);
    return ((r + icfe_pkg::SIDE) % icfe_pkg::SIDE) * icfe_pkg::SIDE
           + ((c + icfe_pkg::SIDE) % icfe_pkg::SIDE);
  endfunction

  function automatic void push_site(ref int stk[$], input int s);
    if (stk.size() < icfe_pkg::STACK_DEPTH) stk.push_back(s);
  endfunction

  function automatic flip_result_t grow_cluster(int r0, int c0);
    int stk[$];
    int seed;
    int cur;
    int r;
    int c;
    int tried;
    int en;
    int mag;
    int sv;
    int nb[4];
    bit orig;
    flip_result_t res;
    seed = site_of(r0, c0);
    orig = lat_spin[seed];
    lat_spin[seed] = ~orig;
    lat_mark[seed] = 1'b1;
    tried = 1;
    nb[0] = site_of(r0 - 1, c0);
    nb[1] = site_of(r0 + 1, c0);
    nb[2] = site_of(r0, c0 - 1);
    nb[3] = site_of(r0, c0 + 1);
    foreach (nb[k]) if (lat_spin[nb[k]] == orig) push_site(stk, nb[k]);
    while (stk.size() > 0) begin
      cur = stk.pop_back();
      tried++;
      if (lat_spin[cur] != orig) continue;
      prng_q = prng_q ^ (prng_q << 13);
      prng_q = prng_q ^ (prng_q >> 17);
      prng_q = prng_q ^ (prng_q << 5);
      if (prng_q[31:16] >= thr_q) continue;
      lat_spin[cur] = ~orig;
      lat_mark[cur] = 1'b1;
      r = cur / icfe_pkg::SIDE;
      c = cur % icfe_pkg::SIDE;
      nb[0] = site_of(r + 1, c);
      nb[1] = site_of(r - 1, c);
      nb[2] = site_of(r, c + 1);
      nb[3] = site_of(r, c - 1);
      foreach (nb[k]) if (!lat_mark[nb[k]]) push_site(stk, nb[k]);
    end
    lat_mark = '0;
    en = 0;
    mag = 0;
    for (r = 0; r < icfe_pkg::SIDE; r++) begin
      for (c = 0; c < icfe_pkg::SIDE; c++) begin
        sv = lat_spin[site_of(r, c)] ? 1 : -1;
        en -= sv * ((lat_spin[site_of(r, c + 1)] ? 1 : -1) +
                    (lat_spin[site_of(r + 1, c)] ? 1 : -1));
        mag += sv;
      end
    end
    if (mag < 0) mag = -mag;
    res.tried = icfe_pkg::TRIED_W'(tried);
    res.energy = icfe_pkg::ENERGY_W'(en);
    res.mag = icfe_pkg::MAG_W'(mag);
    return res;
  endfunction

  // source side
  always @(posedge clk) begin
    logic nv;
    logic [icfe_pkg::IN_DATA_W-1:0] nd;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      src_gap <= 0;
    end else begin
      nv = s_axis_tvalid;
      nd = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_flips.push_back(grow_cluster(int'(s_axis_tdata[4:0]),
                                              int'(s_axis_tdata[9:5])));
        nv = 1'b0;
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
        end else if (seed_sites.size() > 0) begin
          nv = 1'b1;
          nd = seed_sites.pop_front();
          if (!quiet && $urandom_range(0, 3) == 0) src_gap <= $urandom_range(1, 15);
        end
      end
      s_axis_tvalid <= nv;
      s_axis_tdata <= nd;
    end
  end

  // sink side and checking
  always @(posedge clk) begin
    flip_result_t got;
    flip_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[36:0];
        if (expected_flips.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_flips.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: tried %0d/%0d energy %0d/%0d mag %0d/%0d (exp/got)",
                       want.tried, got.tried, $signed(want.energy), $signed(got.energy),
                       want.mag, got.mag);
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        snk_gap <= $urandom_range(0, 14);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [icfe_pkg::CFG_IDX_W-1:0] idx,
                           logic [icfe_pkg::PRNG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == icfe_pkg::REG_THRESHOLD) thr_q = val[icfe_pkg::THR_W-1:0];
    else if (idx == icfe_pkg::REG_SEED) prng_q = (val == '0) ? 32'd1 : val;
  endtask

  task automatic queue_site(int r, int c);
    seed_sites.push_back(icfe_pkg::IN_DATA_W'({c[4:0], r[4:0]}));
  endtask

  // hold until every seed is sent and every result is back
  task automatic drain();
    do @(posedge clk);
    while (seed_sites.size() > 0 || s_axis_tvalid || expected_flips.size() > 0);
  endtask

  task automatic random_phase(int n);
    repeat (n) queue_site($urandom_range(0, 31), $urandom_range(0, 31));
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    quiet = 1'b0;
    cycles = 0;
    lat_spin = '1;
    lat_mark = '0;
    thr_q = '0;
    prng_q = 32'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // threshold zero after reset: only seeds flip, corners wrap around
    queue_site(0, 0);
    queue_site(31, 31);
    queue_site(0, 31);
    queue_site(31, 0);
    queue_site(0, 0);
    queue_site(16, 5);
    drain();
    // full acceptance flips the whole connected domain
    write_reg(icfe_pkg::REG_THRESHOLD, 32'd65535);
    queue_site(10, 10);
    queue_site(31, 0);
    queue_site(0, 31);
    drain();
    // zero seed loads one; unused index is dropped
    write_reg(icfe_pkg::REG_SEED, 32'd0);
    write_reg(icfe_pkg::REG_THRESHOLD, 32'd38400);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    queue_site(5, 27);
    queue_site(26, 4);
    queue_site(31, 31);
    queue_site(0, 0);
    drain();
    write_reg(icfe_pkg::REG_SEED, 32'hFFFF_FFFF);
    write_reg(icfe_pkg::REG_THRESHOLD, 32'd1);
    queue_site(21, 10);
    queue_site(10, 21);
    drain();

    write_reg(icfe_pkg::REG_THRESHOLD, $urandom_range(0, 20000));
    write_reg(icfe_pkg::REG_SEED, $urandom_range(1, 32'hFFFF_FFFF));
    random_phase(30);
    write_reg(icfe_pkg::REG_THRESHOLD, 32'd65535);
    random_phase(8);
    write_reg(icfe_pkg::REG_THRESHOLD, $urandom_range(0, 65535));
    write_reg(icfe_pkg::REG_SEED, $urandom);
    random_phase(30);
    write_reg(icfe_pkg::REG_THRESHOLD, $urandom_range(30000, 45000));
    random_phase(30);
    write_reg(icfe_pkg::REG_THRESHOLD, $urandom_range(0, 38000));
    write_reg(icfe_pkg::REG_SEED, 32'h8000_0000);
    quiet = 1'b1;
    random_phase(40);

    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_flips.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
